[hw/rtl/rc5ir_pkg.sv]
// rc5ir_pkg: transaction payload types, configuration types and constants
// for the rc5 infrared pulse decoder. No dependencies.

package rc5ir_pkg;

   // fixed field widths of the transaction payloads
   localparam int CAPTURE_W = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int HALF_COUNT_W = 6;
   localparam int COMMAND_W = 6;
   localparam int ADDRESS_W = 5;

   // bit positions of the frame fields inside the shifted frame word
   localparam int COMMAND_LSB = 0;
   localparam int ADDRESS_LSB = 6;
   localparam int TOGGLE_POS = 11;

   // operation codes
   localparam logic OP_EDGE = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_PULSE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_LIMIT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_BIT = 2'd2;

   // configuration reset values in timer ticks
   localparam logic [CSR_DATA_W-1:0] MIN_PULSE_RESET = 16'd640;
   localparam logic [CSR_DATA_W-1:0] SHORT_LIMIT_RESET = 16'd1140;
   localparam logic [CSR_DATA_W-1:0] MAX_BIT_RESET = 16'd2000;

   typedef struct packed {
      logic                 op;
      logic [CAPTURE_W-1:0] capture_time;
   } req_type;

   typedef struct packed {
      logic [COMMAND_W-1:0] command;
      logic [ADDRESS_W-1:0] address;
      logic                 toggle;
      logic                 key_ready;
      logic                 frame_done;
      logic                 watch_rising;
   } rsp_type;

   // pulse width thresholds handed to the decode step
   typedef struct packed {
      logic [CSR_DATA_W-1:0] min_pulse;
      logic [CSR_DATA_W-1:0] short_limit;
      logic [CSR_DATA_W-1:0] max_bit;
   } cfg_type;

endpackage

[hw/rtl/rc5ir_decode.sv]
// rc5ir_decode: decoder state and the combinational step that classifies one
// pulse and shifts in frame bits. Depends on rc5ir_pkg.

module rc5ir_decode import rc5ir_pkg::*; #(
   parameter int FRAME_BITS = 13,
   parameter int TIMER_WIDTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    step_en,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   localparam int CMP_W = TIMER_WIDTH + CSR_DATA_W;
   localparam int BITS_W = $clog2(FRAME_BITS + 1);
   localparam int EXT_W = FRAME_BITS + TOGGLE_POS + 1;

   logic [TIMER_WIDTH-1:0]  last_capture_ff, last_capture_in;
   logic                    edge_sense_ff, edge_sense_in;
   logic [HALF_COUNT_W-1:0] half_count_ff, half_count_in;
   logic [BITS_W-1:0]       bits_taken_ff, bits_taken_in;
   logic [FRAME_BITS-1:0]   shift_data_ff, shift_data_in;
   logic                    pending_ff, pending_in;
   logic [COMMAND_W-1:0]    held_command_ff, held_command_in;
   logic [ADDRESS_W-1:0]    held_address_ff, held_address_in;
   logic                    held_toggle_ff, held_toggle_in;

   logic [TIMER_WIDTH+CAPTURE_W-1:0] capture_ext;
   logic [TIMER_WIDTH-1:0]  now_time;
   logic [TIMER_WIDTH-1:0]  pulse_width;
   logic                    too_long;
   logic                    too_short;
   logic                    full_bit;
   logic                    edge_toggled;
   logic [FRAME_BITS-1:0]   shift_next;
   logic [EXT_W-1:0]        shift_ext;
   logic [BITS_W-1:0]       bits_next;
   logic [HALF_COUNT_W-1:0] half_base;
   logic [HALF_COUNT_W-1:0] half_adj;
   logic                    restart;
   logic                    frame_done;

   // pulse width modulo the timer range and its classification
   assign capture_ext = {{TIMER_WIDTH{1'b0}}, item.capture_time};
   assign now_time = capture_ext[TIMER_WIDTH-1:0];
   assign pulse_width = now_time - last_capture_ff;
   assign too_long = CMP_W'(pulse_width) > CMP_W'(cfg.max_bit);
   assign too_short = CMP_W'(pulse_width) < CMP_W'(cfg.min_pulse);
   assign full_bit = CMP_W'(pulse_width) > CMP_W'(cfg.short_limit);

   // candidate shift with the toggled sense as the new data bit
   assign edge_toggled = ~edge_sense_ff;
   assign shift_next = {shift_data_ff[FRAME_BITS-2:0], edge_toggled};
   assign shift_ext = {{(TOGGLE_POS + 1){1'b0}}, shift_next};
   assign bits_next = bits_taken_ff + 1'b1;

   // next state for one transaction
   always_comb begin
      last_capture_in = last_capture_ff;
      edge_sense_in = edge_sense_ff;
      half_count_in = half_count_ff;
      bits_taken_in = bits_taken_ff;
      shift_data_in = shift_data_ff;
      pending_in = pending_ff;
      held_command_in = held_command_ff;
      held_address_in = held_address_ff;
      held_toggle_in = held_toggle_ff;
      half_base = half_count_ff;
      half_adj = half_count_ff;
      restart = 1'b0;
      frame_done = 1'b0;
      if (item.op == OP_CLEAR) begin
         pending_in = 1'b0;
      end else begin
         last_capture_in = now_time;
         edge_sense_in = edge_toggled;
         half_base = too_long ? '0 : half_count_ff;
         if (half_base == '0) begin
            // first edge of a frame arms decoding
            shift_data_in = '0;
            bits_taken_in = '0;
            edge_sense_in = 1'b1;
            half_count_in = HALF_COUNT_W'(1);
         end else if (too_short) begin
            restart = 1'b1;
         end else begin
            half_adj = full_bit ? half_base + 1'b1 : half_base;
            if (half_adj > HALF_COUNT_W'(1) && !half_adj[0]) begin
               shift_data_in = shift_next;
               bits_taken_in = bits_next;
               if (bits_next >= BITS_W'(FRAME_BITS)) begin
                  // frame complete: latch unless a key is still pending
                  if (!pending_ff) begin
                     held_command_in = shift_ext[COMMAND_LSB +: COMMAND_W];
                     held_address_in = shift_ext[ADDRESS_LSB +: ADDRESS_W];
                     held_toggle_in = shift_ext[TOGGLE_POS];
                  end
                  pending_in = 1'b1;
                  frame_done = 1'b1;
                  restart = 1'b1;
               end
            end
            half_count_in = half_adj + 1'b1;
         end
         if (restart) begin
            half_count_in = '0;
            edge_sense_in = 1'b0;
         end
      end
   end

   // result reflects the state after this transaction
   always_comb begin
      result.command = held_command_in;
      result.address = held_address_in;
      result.toggle = held_toggle_in;
      result.key_ready = pending_in;
      result.frame_done = frame_done;
      result.watch_rising = edge_sense_in;
   end

   // decoder state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         last_capture_ff <= '0;
         edge_sense_ff <= 1'b0;
         half_count_ff <= '0;
         bits_taken_ff <= '0;
         shift_data_ff <= '0;
         pending_ff <= 1'b0;
         held_command_ff <= '0;
         held_address_ff <= '0;
         held_toggle_ff <= 1'b0;
      end else if (step_en) begin
         last_capture_ff <= last_capture_in;
         edge_sense_ff <= edge_sense_in;
         half_count_ff <= half_count_in;
         bits_taken_ff <= bits_taken_in;
         shift_data_ff <= shift_data_in;
         pending_ff <= pending_in;
         held_command_ff <= held_command_in;
         held_address_ff <= held_address_in;
         held_toggle_ff <= held_toggle_in;
      end
   end

endmodule

[hw/rtl/rc5_ir_pulse_decoder.sv]
// rc5_ir_pulse_decoder: top level with request, threshold and result registers.
// Depends on rc5ir_pkg and rc5ir_decode.
// The decode step sits between the request register and the result register.
// Throughput: one transaction per cycle; a stalled result lets the request
// register take one more transaction, then req_ready drops until rsp_ready.
// Reset: synchronous, clears all decoder state and restores the thresholds.

module rc5_ir_pulse_decoder import rc5ir_pkg::*; #(
   parameter int FRAME_BITS = 13,
   parameter int TIMER_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   cfg_type cfg_ff, cfg_in;
   logic    advance;
   logic    req_accept;
   rsp_type step_result;

   // pipeline flow control
   assign advance = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_accept = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign in_valid_in = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   // threshold register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MIN_PULSE:   cfg_in.min_pulse = csr_wdata;
            CSR_SHORT_LIMIT: cfg_in.short_limit = csr_wdata;
            CSR_MAX_BIT:     cfg_in.max_bit = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   // control and threshold registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         cfg_ff.min_pulse <= MIN_PULSE_RESET;
         cfg_ff.short_limit <= SHORT_LIMIT_RESET;
         cfg_ff.max_bit <= MAX_BIT_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff <= cfg_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= step_result;
      end
   end

   rc5ir_decode #(
      .FRAME_BITS  (FRAME_BITS),
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_decode (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_data_ff),
      .cfg     (cfg_ff),
      .result  (step_result)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_data_ff;

endmodule

[hw/rtl/rc5ir_checker.sv]
// rc5ir_checker: port-level assertions for the rc5 infrared pulse decoder,
// bound to the top level. Depends on rc5ir_pkg.

module rc5ir_checker import rc5ir_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // no result may appear right after reset
   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // an empty block takes requests right after reset
   a_ready_after_reset: assert property (@(posedge clock)
      $past(reset) |-> req_ready)
      else $error("request not ready right after reset");

   // a completed frame always leaves a key pending
   a_done_sets_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_done |-> rsp_data.key_ready)
      else $error("frame done without key pending");

   // a completed frame returns to watching the falling edge
   a_done_watch_falling: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_done |-> !rsp_data.watch_rising)
      else $error("frame done while watching rising edge");

   // stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind rc5_ir_pulse_decoder rc5ir_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
